@@ src/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, idle during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/bdr_pkg.sv @@
package bdr_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int COUNT_W       = 5;

  typedef enum logic [2:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_REM_HEAD = 3'd2,
    REQ_REVERSE  = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // Enables for the entry RAM.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

@@ src/bdr_ram.sv @@
module bdr_ram
  import bdr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  ram_ctl_t          ctl,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/bounded_deque_with_reverse.sv @@
// Channel   Handshake            Payload
// -------   ------------------   ------------------------------------
// request   in_valid/in_ready    req_type[2:0], value_in[31:0] signed
// result    out_valid/out_ready  ok, removed_value[31:0] signed, count[4:0]
//
// A successful remove goes through ST_READ (registered RAM read) before its
// result is written; every other item writes its result directly. Items are
// handled one at a time: after a remove, no item is taken until ST_READ ends.
// rst is synchronous: count, front pointer and orientation clear at once;
// the entry RAM keeps its contents and needs no clearing pass.
// A stalled result waits in the output register; the next item is taken
// in the same cycle the waiting result drains.
`include "assert_macros.svh"

module bounded_deque_with_reverse
  import bdr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               req_type,
  input  logic signed [DATA_W-1:0] value_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     ok,
  output logic signed [DATA_W-1:0] removed_value,
  output logic [COUNT_W-1:0]       count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // slot index width
  localparam int CW = $clog2(DEPTH + 1);                // entry count width
  localparam int SW = CW + 1;                           // slot arithmetic width
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  // Step one slot forward/back around the ring.
  function automatic logic [PW-1:0] fwd1(input logic [PW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] back1(input logic [PW-1:0] p);
    return (p == '0) ? LAST_SLOT : p - PW'(1);
  endfunction

  // p + n mod DEPTH, with n < DEPTH: one compare and subtract.
  function automatic logic [PW-1:0] fwd_n(input logic [PW-1:0] p, input logic [CW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(n);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  // p - n mod DEPTH, with n < DEPTH.
  function automatic logic [PW-1:0] back_n(input logic [PW-1:0] p, input logic [CW-1:0] n);
    logic [SW-1:0] s;
    if (SW'(p) >= SW'(n)) begin
      s = SW'(p) - SW'(n);
    end else begin
      s = SW'(p) + SW'(DEPTH) - SW'(n);
    end
    return s[PW-1:0];
  endfunction

  state_t state, state_next;

  logic [PW-1:0] front_pointer, front_pointer_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic          reversed, reversed_next;

  logic              in_fire;
  logic              go_read;
  logic              ok_now;
  ram_ctl_t          ram_ctl;
  logic [PW-1:0]     wr_addr;
  logic [DATA_W-1:0] rd_data;
  req_t              req;

  assign in_fire = in_valid && in_ready;
  assign req     = req_t'(req_type);

  // Request decode and pointer update
  always_comb begin
    front_pointer_next = front_pointer;
    entry_count_next   = entry_count;
    reversed_next      = reversed;
    ok_now             = 1'b0;
    go_read            = 1'b0;
    ram_ctl            = '0;
    wr_addr            = front_pointer;
    if (in_fire) begin
      case (req)
        REQ_INS_HEAD: begin
          if (entry_count != FULL_CNT) begin
            front_pointer_next = reversed ? fwd1(front_pointer) : back1(front_pointer);
            wr_addr            = front_pointer_next;
            ram_ctl.wr_en      = 1'b1;
            entry_count_next   = entry_count + CW'(1);
            ok_now             = 1'b1;
          end
        end
        REQ_INS_TAIL: begin
          if (entry_count != FULL_CNT) begin
            wr_addr          = reversed ? back_n(front_pointer, entry_count)
                                        : fwd_n(front_pointer, entry_count);
            ram_ctl.wr_en    = 1'b1;
            entry_count_next = entry_count + CW'(1);
            ok_now           = 1'b1;
          end
        end
        REQ_REM_HEAD: begin
          if (entry_count != '0) begin
            // head slot is read now; the RAM output is registered, then captured into the result in ST_READ
            ram_ctl.rd_en      = 1'b1;
            go_read            = 1'b1;
            front_pointer_next = reversed ? back1(front_pointer) : fwd1(front_pointer);
            entry_count_next   = entry_count - CW'(1);
            ok_now             = 1'b1;
          end
        end
        REQ_REVERSE: begin
          // front jumps to the old tail, orientation flips; no entry moves
          if (entry_count != '0) begin
            front_pointer_next = reversed ? back_n(front_pointer, entry_count - CW'(1))
                                          : fwd_n(front_pointer, entry_count - CW'(1));
            reversed_next      = !reversed;
          end
          ok_now = 1'b1;
        end
        REQ_CLEAR: begin
          front_pointer_next = '0;
          entry_count_next   = '0;
          reversed_next      = 1'b0;
          ok_now             = 1'b1;
        end
        default: begin
          // unknown request: no change, ok stays low
        end
      endcase
    end
  end

  // FSM next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (go_read) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs: take an item only when idle and the result register frees up
  always_comb begin
    case (state)
      ST_IDLE: in_ready = !out_valid || out_ready;
      ST_READ: in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      front_pointer <= '0;
      entry_count   <= '0;
      reversed      <= 1'b0;
    end else begin
      state         <= state_next;
      front_pointer <= front_pointer_next;
      entry_count   <= entry_count_next;
      reversed      <= reversed_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_READ) begin
      out_valid <= 1'b1;
    end else if (in_fire && !go_read) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      ok            <= 1'b1;
      removed_value <= rd_data;
      count         <= COUNT_W'(entry_count);
    end else if (in_fire && !go_read) begin
      ok            <= ok_now;
      removed_value <= '0;
      count         <= COUNT_W'(entry_count_next);
    end
  end

  bdr_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .wr_addr (wr_addr),
    .wr_data (value_in),
    .rd_addr (front_pointer),
    .rd_data (rd_data)
  );

  // Checks
  `ASSERT_CLK(a_count_bound, entry_count <= FULL_CNT, "entry count above depth")
  `ASSERT_CLK(a_read_one_cycle, state == ST_READ |=> state == ST_IDLE, "read state held")
  `ASSERT_CLK(a_read_reg_free, state == ST_READ |-> !out_valid && !in_ready, "result busy in read")
  `ASSERT_CLK(a_remove_reads, in_fire && req == REQ_REM_HEAD && entry_count != '0 |=> state == ST_READ && entry_count == $past(entry_count) - CW'(1), "remove did not read")

endmodule
